@@ design/blink_and_expression_sequencer_assert.svh @@
// Assertion macros used by the blink and expression sequencer checker.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef BLINK_AND_EXPRESSION_SEQUENCER_ASSERT_SVH
`define BLINK_AND_EXPRESSION_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define BES_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bes assertion failed");

// Next-cycle implication.
`define BES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bes assertion failed");

`endif

@@ design/bes_pkg.sv @@
// Package for the blink and expression sequencer: phase codes, register
// indexes, configuration and state types. No dependencies.
package bes_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned PctW   = 7;
  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
  localparam logic [PhaseW-1:0] PH_CLOSED = 3'd1;
  localparam logic [PhaseW-1:0] PH_REOPEN = 3'd2;
  localparam logic [PhaseW-1:0] PH_GAP    = 3'd3;
  localparam logic [PhaseW-1:0] PH_SHAKE  = 3'd4;

  typedef enum logic [2:0] {
    REG_INTERVAL_MIN = 3'd0,
    REG_INTERVAL_MAX = 3'd1,
    REG_MOUTH_OPEN   = 3'd2,
    REG_CLOSED       = 3'd3,
    REG_REOPEN       = 3'd4,
    REG_GAP          = 3'd5,
    REG_SHAKE        = 3'd6,
    REG_DOUBLE_PCT   = 3'd7
  } reg_idx_e;

  localparam logic [TimerW-1:0] RST_INTERVAL_MIN = 16'd2000;
  localparam logic [TimerW-1:0] RST_INTERVAL_MAX = 16'd6000;
  localparam logic [TimerW-1:0] RST_MOUTH_OPEN   = 16'd300;
  localparam logic [TimerW-1:0] RST_CLOSED       = 16'd120;
  localparam logic [TimerW-1:0] RST_REOPEN       = 16'd80;
  localparam logic [TimerW-1:0] RST_GAP          = 16'd100;
  localparam logic [TimerW-1:0] RST_SHAKE        = 16'd500;
  localparam logic [PctW-1:0]   RST_DOUBLE_PCT   = 7'd20;

  typedef struct packed {
    logic [TimerW-1:0] interval_min;
    logic [TimerW-1:0] interval_max;
    logic [TimerW-1:0] mouth_open;
    logic [TimerW-1:0] closed;
    logic [TimerW-1:0] reopen;
    logic [TimerW-1:0] gap;
    logic [TimerW-1:0] shake;
    logic [PctW-1:0]   double_pct;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] eye_phase;
    logic              mouth_phase;
    logic [TimerW-1:0] eye_timer;
    logic [TimerW-1:0] mouth_timer;
    logic [TimerW-1:0] blink_due;
    logic              second_pending;
  } face_t;

  typedef struct packed {
    logic              restart;
    logic              shake;
    logic              click;
    logic [TimerW-1:0] elapsed_ms;
    logic [TimerW-1:0] interval_draw;
    logic [PctW-1:0]   chance_draw;
  } step_in_t;

endpackage

@@ design/bes_step.sv @@
// Next-state logic for one time step of the face sequencer.
// Depends on bes_pkg.
module bes_step (
  input  bes_pkg::cfg_t     cfg_i,
  input  bes_pkg::face_t    cur_i,
  input  bes_pkg::step_in_t in_i,
  output bes_pkg::face_t    nxt_o
);

  function automatic logic [bes_pkg::TimerW-1:0] clamp_ivl(
    input logic [bes_pkg::TimerW-1:0] draw,
    input logic [bes_pkg::TimerW-1:0] lo,
    input logic [bes_pkg::TimerW-1:0] hi
  );
    logic [bes_pkg::TimerW-1:0] r;
    if (draw < lo) begin
      r = lo;
    end else if (draw > hi) begin
      r = hi;
    end else begin
      r = draw;
    end
    return r;
  endfunction

  logic [bes_pkg::TimerW-1:0] clamped;
  logic [bes_pkg::TimerW-1:0] eye_t;
  logic [bes_pkg::TimerW-1:0] mouth_t;

  assign clamped = clamp_ivl(in_i.interval_draw, cfg_i.interval_min, cfg_i.interval_max);
  assign eye_t   = cur_i.eye_timer + in_i.elapsed_ms;
  assign mouth_t = cur_i.mouth_timer + in_i.elapsed_ms;

  always_comb begin
    nxt_o = cur_i;
    if (in_i.restart) begin
      nxt_o.eye_phase      = bes_pkg::PH_IDLE;
      nxt_o.mouth_phase    = 1'b0;
      nxt_o.eye_timer      = '0;
      nxt_o.mouth_timer    = '0;
      nxt_o.second_pending = 1'b0;
      nxt_o.blink_due      = clamped;
    end else begin
      nxt_o.eye_timer   = eye_t;
      nxt_o.mouth_timer = mouth_t;
      if (in_i.click) begin
        nxt_o.mouth_phase = 1'b1;
        nxt_o.mouth_timer = '0;
      end
      if (nxt_o.mouth_phase && (nxt_o.mouth_timer >= cfg_i.mouth_open)) begin
        nxt_o.mouth_phase = 1'b0;
        nxt_o.mouth_timer = '0;
      end

      if (in_i.shake) begin
        nxt_o.eye_phase      = bes_pkg::PH_SHAKE;
        nxt_o.eye_timer      = '0;
        nxt_o.second_pending = 1'b0;
      end else begin
        unique case (cur_i.eye_phase)
          bes_pkg::PH_IDLE: begin
            if (eye_t >= cur_i.blink_due) begin
              nxt_o.eye_phase      = bes_pkg::PH_CLOSED;
              nxt_o.eye_timer      = '0;
              nxt_o.second_pending = (in_i.chance_draw < cfg_i.double_pct);
            end
          end
          bes_pkg::PH_CLOSED: begin
            if (eye_t >= cfg_i.closed) begin
              nxt_o.eye_phase = bes_pkg::PH_REOPEN;
              nxt_o.eye_timer = '0;
            end
          end
          bes_pkg::PH_REOPEN: begin
            if (eye_t >= cfg_i.reopen) begin
              nxt_o.eye_timer = '0;
              if (cur_i.second_pending) begin
                nxt_o.eye_phase      = bes_pkg::PH_GAP;
                nxt_o.second_pending = 1'b0;
              end else begin
                nxt_o.eye_phase = bes_pkg::PH_IDLE;
                nxt_o.blink_due = clamped;
              end
            end
          end
          bes_pkg::PH_GAP: begin
            if (eye_t >= cfg_i.gap) begin
              nxt_o.eye_phase = bes_pkg::PH_CLOSED;
              nxt_o.eye_timer = '0;
            end
          end
          default: begin
            if (eye_t >= cfg_i.shake) begin
              nxt_o.eye_phase = bes_pkg::PH_IDLE;
              nxt_o.eye_timer = '0;
              nxt_o.blink_due = clamped;
            end
          end
        endcase
      end
    end
  end

endmodule

@@ design/blink_and_expression_sequencer.sv @@
// Blink and expression sequencer: one time step per clock, one result per step,
// while the output is not back-pressured. The result is valid the cycle after the
// input transfer, from the combinational face state update and one output register.
// Reset (rst_ni low, asynchronous): config, face and valid registers to defaults,
// face idle and neutral, blink interval at interval_min default; no clearing pass.
// Depends on bes_pkg and bes_step.
module blink_and_expression_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // shake, click, elapsed_ms[15:0], interval_draw[15:0], chance_draw[6:0], pad
  input  logic [47:0] s_axis_tdata_i,
  // restart
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // eyes_mode[2:0], mouth_open, pad
  output logic [7:0]  m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bes_pkg::cfg_t     cfg_q;
  bes_pkg::face_t    face_q, face_d;
  bes_pkg::step_in_t step_in;
  logic              in_xfer;
  logic              out_valid_q;
  logic [7:0]        out_data_q;
  logic              cfg_wr;
  bes_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = bes_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_min <= bes_pkg::RST_INTERVAL_MIN;
      cfg_q.interval_max <= bes_pkg::RST_INTERVAL_MAX;
      cfg_q.mouth_open   <= bes_pkg::RST_MOUTH_OPEN;
      cfg_q.closed       <= bes_pkg::RST_CLOSED;
      cfg_q.reopen       <= bes_pkg::RST_REOPEN;
      cfg_q.gap          <= bes_pkg::RST_GAP;
      cfg_q.shake        <= bes_pkg::RST_SHAKE;
      cfg_q.double_pct   <= bes_pkg::RST_DOUBLE_PCT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bes_pkg::REG_INTERVAL_MIN: cfg_q.interval_min <= pwdata[15:0];
        bes_pkg::REG_INTERVAL_MAX: cfg_q.interval_max <= pwdata[15:0];
        bes_pkg::REG_MOUTH_OPEN:   cfg_q.mouth_open   <= pwdata[15:0];
        bes_pkg::REG_CLOSED:       cfg_q.closed       <= pwdata[15:0];
        bes_pkg::REG_REOPEN:       cfg_q.reopen       <= pwdata[15:0];
        bes_pkg::REG_GAP:          cfg_q.gap          <= pwdata[15:0];
        bes_pkg::REG_SHAKE:        cfg_q.shake        <= pwdata[15:0];
        bes_pkg::REG_DOUBLE_PCT:   cfg_q.double_pct   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bes_pkg::REG_INTERVAL_MIN: prdata = {16'd0, cfg_q.interval_min};
      bes_pkg::REG_INTERVAL_MAX: prdata = {16'd0, cfg_q.interval_max};
      bes_pkg::REG_MOUTH_OPEN:   prdata = {16'd0, cfg_q.mouth_open};
      bes_pkg::REG_CLOSED:       prdata = {16'd0, cfg_q.closed};
      bes_pkg::REG_REOPEN:       prdata = {16'd0, cfg_q.reopen};
      bes_pkg::REG_GAP:          prdata = {16'd0, cfg_q.gap};
      bes_pkg::REG_SHAKE:        prdata = {16'd0, cfg_q.shake};
      bes_pkg::REG_DOUBLE_PCT:   prdata = {25'd0, cfg_q.double_pct};
      default:                   prdata = '0;
    endcase
  end

  // Output register frees up whenever its result is taken in the same cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign step_in.restart       = s_axis_tuser_i;
  assign step_in.shake         = s_axis_tdata_i[0];
  assign step_in.click         = s_axis_tdata_i[1];
  assign step_in.elapsed_ms    = s_axis_tdata_i[17:2];
  assign step_in.interval_draw = s_axis_tdata_i[33:18];
  assign step_in.chance_draw   = s_axis_tdata_i[40:34];

  bes_step u_step (
    .cfg_i (cfg_q),
    .cur_i (face_q),
    .in_i  (step_in),
    .nxt_o (face_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_q.eye_phase      <= bes_pkg::PH_IDLE;
      face_q.mouth_phase    <= 1'b0;
      face_q.eye_timer      <= '0;
      face_q.mouth_timer    <= '0;
      face_q.blink_due      <= bes_pkg::RST_INTERVAL_MIN;
      face_q.second_pending <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      if (in_xfer) begin
        face_q      <= face_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {4'd0, face_d.mouth_phase, face_d.eye_phase};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ design/bes_checker.sv @@
// Port-level checker for the blink and expression sequencer, bound to the top.
// Depends on blink_and_expression_sequencer_assert.svh.
`include "blink_and_expression_sequencer_assert.svh"

module bes_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  logic in_xfer;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  `BES_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))
  `BES_ASSERT_NEXT(a_in_gives_out, in_xfer, m_axis_tvalid_o)
  `BES_ASSERT_NEXT(a_restart_clear, in_xfer && s_axis_tuser_i, m_axis_tdata_o == 8'd0)
  `BES_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid_o, s_axis_tready_o)

endmodule

bind blink_and_expression_sequencer bes_checker u_bes_checker (.*);

@@ sim/blink_and_expression_sequencer_tb.sv @@
// Self-checking testbench for blink_and_expression_sequencer: stream stimulus, APB register
// setup and a scoreboard class that predicts the eye and mouth state of every step.
// Depends on bes_pkg and the sequencer RTL.
module blink_and_expression_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bes_pkg::PhaseW-1:0] eyes;
    logic                       mouth;
  } face_out_t;

  class face_scoreboard;
    bes_pkg::cfg_t  cfg;
    bes_pkg::face_t face;
    face_out_t      face_q[$];
    int unsigned errors, steps, faces_seen, blinks, doubles, shakes, clicks, restarts;

    function void power_on();
      cfg.interval_min = bes_pkg::RST_INTERVAL_MIN;
      cfg.interval_max = bes_pkg::RST_INTERVAL_MAX;
      cfg.mouth_open   = bes_pkg::RST_MOUTH_OPEN;
      cfg.closed       = bes_pkg::RST_CLOSED;
      cfg.reopen       = bes_pkg::RST_REOPEN;
      cfg.gap          = bes_pkg::RST_GAP;
      cfg.shake        = bes_pkg::RST_SHAKE;
      cfg.double_pct   = bes_pkg::RST_DOUBLE_PCT;
      face             = '0;
      face.eye_phase   = bes_pkg::PH_IDLE;
      face.blink_due   = bes_pkg::RST_INTERVAL_MIN;
    endfunction

    function void set_reg(bes_pkg::reg_idx_e idx, logic [31:0] val);
      unique case (idx)
        bes_pkg::REG_INTERVAL_MIN: cfg.interval_min = val[bes_pkg::TimerW-1:0];
        bes_pkg::REG_INTERVAL_MAX: cfg.interval_max = val[bes_pkg::TimerW-1:0];
        bes_pkg::REG_MOUTH_OPEN:   cfg.mouth_open   = val[bes_pkg::TimerW-1:0];
        bes_pkg::REG_CLOSED:       cfg.closed       = val[bes_pkg::TimerW-1:0];
        bes_pkg::REG_REOPEN:       cfg.reopen       = val[bes_pkg::TimerW-1:0];
        bes_pkg::REG_GAP:          cfg.gap          = val[bes_pkg::TimerW-1:0];
        bes_pkg::REG_SHAKE:        cfg.shake        = val[bes_pkg::TimerW-1:0];
        default:                   cfg.double_pct   = val[bes_pkg::PctW-1:0];
      endcase
    endfunction

    function logic [bes_pkg::TimerW-1:0] clamp_interval(logic [bes_pkg::TimerW-1:0] draw);
      if (draw < cfg.interval_min) return cfg.interval_min;
      if (draw > cfg.interval_max) return cfg.interval_max;
      return draw;
    endfunction

    function void note_step(bes_pkg::step_in_t st);
      face_out_t e;
      steps++;
      if (st.restart) begin
        restarts++;
        face           = '0;
        face.eye_phase = bes_pkg::PH_IDLE;
        face.blink_due = clamp_interval(st.interval_draw);
      end else begin
        face.eye_timer   = face.eye_timer + st.elapsed_ms;
        face.mouth_timer = face.mouth_timer + st.elapsed_ms;
        if (st.click) begin
          clicks++;
          face.mouth_phase = 1'b1;
          face.mouth_timer = '0;
        end
        if (face.mouth_phase && face.mouth_timer >= cfg.mouth_open) begin
          face.mouth_phase = 1'b0;
          face.mouth_timer = '0;
        end
        if (st.shake) begin
          shakes++;
          face.eye_phase      = bes_pkg::PH_SHAKE;
          face.eye_timer      = '0;
          face.second_pending = 1'b0;
        end else begin
          unique case (face.eye_phase)
            bes_pkg::PH_IDLE: begin
              if (face.eye_timer >= face.blink_due) begin
                blinks++;
                face.eye_phase      = bes_pkg::PH_CLOSED;
                face.eye_timer      = '0;
                face.second_pending = st.chance_draw < cfg.double_pct;
              end
            end
            bes_pkg::PH_CLOSED: begin
              if (face.eye_timer >= cfg.closed) begin
                face.eye_phase = bes_pkg::PH_REOPEN;
                face.eye_timer = '0;
              end
            end
            bes_pkg::PH_REOPEN: begin
              if (face.eye_timer >= cfg.reopen) begin
                face.eye_timer = '0;
                if (face.second_pending) begin
                  doubles++;
                  face.eye_phase      = bes_pkg::PH_GAP;
                  face.second_pending = 1'b0;
                end else begin
                  face.eye_phase = bes_pkg::PH_IDLE;
                  face.blink_due = clamp_interval(st.interval_draw);
                end
              end
            end
            bes_pkg::PH_GAP: begin
              if (face.eye_timer >= cfg.gap) begin
                face.eye_phase = bes_pkg::PH_CLOSED;
                face.eye_timer = '0;
              end
            end
            default: begin
              if (face.eye_timer >= cfg.shake) begin
                face.eye_phase = bes_pkg::PH_IDLE;
                face.eye_timer = '0;
                face.blink_due = clamp_interval(st.interval_draw);
              end
            end
          endcase
        end
      end
      e.eyes  = face.eye_phase;
      e.mouth = face.mouth_phase;
      face_q.push_back(e);
    endfunction

    function void check_face(logic [bes_pkg::PhaseW-1:0] eyes, logic mouth);
      face_out_t e;
      faces_seen++;
      if (face_q.size() == 0) begin
        $display("%0t: unexpected result, eyes %0d mouth %0d", $time, eyes, mouth);
        errors++;
        return;
      end
      e = face_q.pop_front();
      if (eyes !== e.eyes) begin
        $display("%0t: eyes_mode expected %0d actual %0d", $time, e.eyes, eyes);
        errors++;
      end
      if (mouth !== e.mouth) begin
        $display("%0t: mouth_open expected %0d actual %0d", $time, e.mouth, mouth);
        errors++;
      end
    endfunction

    function int pending();
      return face_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  face_scoreboard sb;
  bit             calm;
  int unsigned    settings;

  blink_and_expression_sequencer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("blink_and_expression_sequencer_tb: FAIL");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bes_pkg::step_in_t mk(bit restart, bit shake, bit click,
                                           int unsigned elapsed, int unsigned draw,
                                           int unsigned chance);
    bes_pkg::step_in_t st;
    st.restart       = restart;
    st.shake         = shake;
    st.click         = click;
    st.elapsed_ms    = elapsed[bes_pkg::TimerW-1:0];
    st.interval_draw = draw[bes_pkg::TimerW-1:0];
    st.chance_draw   = chance[bes_pkg::PctW-1:0];
    return st;
  endfunction

  function automatic bes_pkg::step_in_t rand_step(int unsigned scale);
    bes_pkg::step_in_t st;
    int unsigned       r;
    r = $urandom_range(0, 99);
    st.restart = ($urandom_range(0, 99) < 2);
    st.shake   = ($urandom_range(0, 99) < 4);
    st.click   = ($urandom_range(0, 99) < 10);
    if (r < 80)      st.elapsed_ms = 16'($urandom_range(0, scale));
    else if (r < 90) st.elapsed_ms = 16'($urandom);
    else if (r < 95) st.elapsed_ms = '0;
    else             st.elapsed_ms = '1;
    st.interval_draw = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 4 * scale));
    st.chance_draw   = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                   : 7'($urandom_range(0, 99));
    return st;
  endfunction

  function automatic bes_pkg::cfg_t phase_cfg(input int p, output int unsigned scale);
    bes_pkg::cfg_t c;
    unique case (p)
      0: begin
        c = '{interval_min: 10, interval_max: 400, mouth_open: 150, closed: 60,
              reopen: 40, gap: 50, shake: 200, double_pct: 50};
        scale = 100;
      end
      1: begin
        c = '0;
        c.double_pct = 100;
        scale = 20;
      end
      2: begin
        c = '{interval_min: 600, interval_max: 90, mouth_open: 16'($urandom_range(0, 255)),
              closed: 16'($urandom_range(0, 255)), reopen: 16'($urandom_range(0, 255)),
              gap: 16'($urandom_range(0, 255)), shake: 16'($urandom_range(0, 255)),
              double_pct: 127};
        scale = 150;
      end
      3: begin
        c = '{interval_min: 0, interval_max: 16'hFFFF, mouth_open: 16'hFFFF,
              closed: 16'hFFFF, reopen: 16'hFFFF, gap: 16'hFFFF, shake: 16'hFFFF,
              double_pct: 0};
        scale = 65535;
      end
      default: begin
        c.interval_min = 16'($urandom_range(0, 500));
        c.interval_max = 16'($urandom_range(0, 800));
        c.mouth_open   = 16'($urandom_range(0, 300));
        c.closed       = 16'($urandom_range(0, 300));
        c.reopen       = 16'($urandom_range(0, 300));
        c.gap          = 16'($urandom_range(0, 300));
        c.shake        = 16'($urandom_range(0, 300));
        c.double_pct   = 7'($urandom_range(0, 100));
        scale = 120;
      end
    endcase
    return c;
  endfunction

  task automatic send_step(bes_pkg::step_in_t st);
    int unsigned gap;
    bit          ok;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, st.chance_draw, st.interval_draw, st.elapsed_ms,
                        st.click, st.shake};
    s_axis_tuser_i  <= st.restart;
    do begin
      @(negedge clk_i);
      ok = (s_axis_tready_o === 1'b1);
      if (ok) sb.note_step(st);
      @(posedge clk_i);
    end while (!ok);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic reg_write(bes_pkg::reg_idx_e idx, logic [31:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (pready !== 1'b1);
    @(posedge clk_i);
    sb.set_reg(idx, val);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      $display("%0t: register %0d readback expected %0h actual %0h", $time, idx, val, rd);
      sb.errors++;
    end
  endtask

  task automatic apply_cfg(bes_pkg::cfg_t c);
    reg_write(bes_pkg::REG_INTERVAL_MIN, 32'(c.interval_min));
    reg_write(bes_pkg::REG_INTERVAL_MAX, 32'(c.interval_max));
    reg_write(bes_pkg::REG_MOUTH_OPEN,   32'(c.mouth_open));
    reg_write(bes_pkg::REG_CLOSED,       32'(c.closed));
    reg_write(bes_pkg::REG_REOPEN,       32'(c.reopen));
    reg_write(bes_pkg::REG_GAP,          32'(c.gap));
    reg_write(bes_pkg::REG_SHAKE,        32'(c.shake));
    reg_write(bes_pkg::REG_DOUBLE_PCT,   32'(c.double_pct));
    settings++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1)
      sb.check_face(m_axis_tdata_o[2:0], m_axis_tdata_o[3]);
  end

  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        hold--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) hold = pick_gap() + 1;
      end
    end
  end

  initial begin
    bes_pkg::step_in_t directed[$];
    bes_pkg::cfg_t     c;
    int unsigned       scale;
    sb = new();
    sb.power_on();
    calm            = 1'b0;
    settings        = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // blink with double, mouth open and close, shake, timer wrap, restart with noise
    directed = '{mk(1, 0, 0, 0, 4000, 0),      mk(1, 1, 1, 65535, 0, 127),
                 mk(0, 0, 0, 1999, 0, 0),      mk(0, 0, 0, 1, 0, 0),
                 mk(0, 0, 0, 120, 0, 0),       mk(0, 0, 0, 80, 0, 0),
                 mk(0, 0, 0, 100, 0, 0),       mk(0, 0, 0, 120, 0, 0),
                 mk(0, 0, 0, 80, 65535, 0),    mk(0, 0, 1, 0, 0, 0),
                 mk(0, 0, 0, 299, 0, 0),       mk(0, 0, 0, 1, 0, 0),
                 mk(0, 1, 0, 5, 0, 0),         mk(0, 1, 1, 65535, 65535, 127),
                 mk(0, 0, 0, 500, 3000, 0),    mk(0, 0, 0, 2999, 0, 19),
                 mk(0, 0, 0, 1, 0, 19),        mk(0, 0, 0, 65535, 0, 0),
                 mk(0, 0, 0, 65535, 0, 0),     mk(0, 0, 0, 65535, 0, 0),
                 mk(0, 0, 0, 120, 0, 0),       mk(0, 0, 0, 80, 0, 20),
                 mk(0, 0, 0, 2000, 0, 20),     mk(0, 0, 0, 120, 0, 0),
                 mk(0, 0, 0, 80, 65535, 0)};
    foreach (directed[i]) send_step(directed[i]);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      c = phase_cfg(p, scale);
      apply_cfg(c);
      calm = (p == 1 || p == 5);
      for (int n = 0; n < 105; n++) begin
        send_step(rand_step(scale));
        if (p == 4 && n == 50) wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("Ran %0d steps under %0d register settings: %0d blinks, %0d doubles,",
             sb.steps, settings, sb.blinks, sb.doubles);
    $display("  %0d shakes, %0d clicks, %0d restarts, %0d results checked",
             sb.shakes, sb.clicks, sb.restarts, sb.faces_seen);
    if (sb.errors == 0) begin
      $display("blink_and_expression_sequencer_tb: PASS");
    end else begin
      $display("blink_and_expression_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
